/* rtl/rwc_pkg.sv */
// ----------------------------------------------------------------------------
// rwc_pkg: shared types and constants of the row weighted centroid unit
// Payload structs, controller command and status groups, datapath widths.
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int MAX_WIDTH = 1024;

  localparam int GRAD_W = 16;
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int PROD_W = COL_W + GRAD_W + 1;
  localparam int PACC_W = 27;
  localparam int WACC_W = 38;
  localparam int LOC_W  = 19;
  localparam int MIN_W  = 26;

  // divider operands: numerator is (weighted sum << 8) + den/2, denominator a positive sum
  localparam int DEN_W = PACC_W - 1;
  localparam int NUM_W = WACC_W + 8;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int LOC_MAX_INT   = (1 << LOC_W) - 1;
  localparam int LIMIT_INT     = (MAX_WIDTH * 256 > LOC_MAX_INT) ? LOC_MAX_INT
                                                                 : MAX_WIDTH * 256;
  localparam logic [LOC_W-1:0] LOC_LIMIT = LOC_W'(LIMIT_INT);

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MIN_WEIGHT_SUM = 1'b0;
  localparam logic [MIN_W-1:0] MIN_SUM_RESET = MIN_W'(1);

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic                     last_in_row;
  } rwc_in_t;

  typedef struct packed {
    logic [LOC_W-1:0] row_location;
    logic             below_threshold;
    logic             clamped;
    logic             too_long;
  } rwc_out_t;

  typedef struct packed {
    logic acc_en;
    logic div_start;
    logic out_load;
    logic acc_clear;
  } rwc_cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_done;
    logic out_free;
  } rwc_sts_t;

endpackage

/* rtl/rwc_div.sv */
// ----------------------------------------------------------------------------
// rwc_div: restoring divider
// Unsigned division, one quotient bit per cycle, quotient left in num_q.
// ----------------------------------------------------------------------------
module rwc_div import rwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit, subtract when it fits
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* rtl/rwc_dp.sv */
// ----------------------------------------------------------------------------
// rwc_dp: accumulation, threshold test, division and result register
// Column count, plain and weighted sums, quotient saturation, output stage.
// ----------------------------------------------------------------------------
module rwc_dp import rwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rwc_cmd_t         cmd_i,
  output rwc_sts_t         sts_o,
  input  rwc_in_t          in_data_i,
  input  logic [MIN_W-1:0] min_sum_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rwc_out_t         out_data_o
);

  logic [COL_W-1:0]         col_q, col_d;
  logic                     ovf_q, ovf_d;
  logic [PACC_W-1:0]        pacc_q, pacc_d;
  logic [WACC_W-1:0]        wacc_q, wacc_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  rwc_out_t                 out_q, out_d;
  logic                     out_valid_q;

  logic             below, negative;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic             div_busy, div_done;
  logic [NUM_W-1:0] quot;

  // column and sums
  always_comb begin
    col_d  = col_q;
    ovf_d  = ovf_q;
    pacc_d = pacc_q;
    wacc_d = wacc_q;
    if (prod_vld_q) begin
      wacc_d = wacc_q + {{(WACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (cmd_i.acc_en) begin
      if (col_q < COL_W'(MAX_WIDTH)) begin
        col_d = col_q + COL_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      pacc_d = pacc_q + {{(PACC_W-GRAD_W){in_data_i.gradient[GRAD_W-1]}},
                         in_data_i.gradient};
    end
    if (cmd_i.acc_clear) begin
      col_d  = '0;
      ovf_d  = 1'b0;
      pacc_d = '0;
      wacc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      ovf_q      <= 1'b0;
      pacc_q     <= '0;
      wacc_q     <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      ovf_q      <= ovf_d;
      pacc_q     <= pacc_d;
      wacc_q     <= wacc_d;
      prod_vld_q <= cmd_i.acc_en;
    end
  end

  // weight by the column the sample lands in; the registered product is added to the sum in the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      prod_q <= $signed({1'b0, col_d}) * in_data_i.gradient;
    end
  end

  // row tests on the finished sums
  assign below    = pacc_q[PACC_W-1] || (pacc_q == '0) ||
                    (pacc_q[DEN_W-1:0] < min_sum_i);
  assign negative = wacc_q[WACC_W-1];
  assign den      = pacc_q[DEN_W-1:0];
  assign num      = {1'b0, wacc_q[WACC_W-2:0], 8'h00} + NUM_W'(den >> 1);

  rwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    out_d                 = '0;
    out_d.too_long        = ovf_q;
    if (below) begin
      out_d.below_threshold = 1'b1;
    end else if (negative) begin
      out_d.clamped = 1'b1;
    end else if (quot > NUM_W'(LOC_LIMIT)) begin
      out_d.row_location = LOC_LIMIT;
      out_d.clamped      = 1'b1;
    end else begin
      out_d.row_location = quot[LOC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign sts_o.skip_div = below || negative;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  a_no_sample_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !cmd_i.acc_en && !cmd_i.acc_clear)
    else $error("sums changed during division");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.below_threshold && out_q.clamped))
    else $error("below threshold and clamped together");

  a_location_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.row_location <= LOC_LIMIT))
    else $error("location beyond limit");

endmodule

/* rtl/rwc_ctrl.sv */
// ----------------------------------------------------------------------------
// rwc_ctrl: row sequencer
// Takes samples, then at row end runs threshold test, division unless skipped, and output.
// ----------------------------------------------------------------------------
module rwc_ctrl import rwc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  rwc_sts_t sts_i,
  output rwc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_ACC,
    S_FLUSH,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_ACC);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_ACC: begin
        cmd_o.acc_en = accept;
        if (accept && in_last_i) begin
          state_d = S_FLUSH;
        end
      end
      // let the last weighted product reach its sum
      S_FLUSH: state_d = S_CHECK;
      S_CHECK: begin
        if (sts_i.skip_div) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.acc_clear = 1'b1;
          state_d         = S_ACC;
        end
      end
      default: state_d = S_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/row_weighted_centroid_unit.sv */
// ----------------------------------------------------------------------------
// row_weighted_centroid_unit: per-row weighted centroid of a gradient stream
// Sums samples and column-weighted samples per row, divides at row end.
//
//   channel   dir  handshake                 payload
//   in        in   in_valid_i / in_ready_o   rwc_in_t  (gradient, last_in_row)
//   out       out  out_valid_o / out_ready_i rwc_out_t (row_location, flags)
//   config    in   APB psel/penable/pready   min_weight_sum at address 0
//
// Samples are taken one per cycle within a row. After the last sample of a
// row the input is held through the flush, check and done states when the
// row is below threshold or has a negative weighted sum, else also while the
// divider runs its 46 steps and raises its done flag. The result sits in an
// output register; a stalled output holds the next row only at its end.
// Reset is asynchronous: sums clear, min_weight_sum reads 1.
// ----------------------------------------------------------------------------
module row_weighted_centroid_unit import rwc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rwc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rwc_out_t              out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  rwc_cmd_t         cmd;
  rwc_sts_t         sts;
  logic [MIN_W-1:0] min_sum_q;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_MIN_WEIGHT_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sum_q <= MIN_SUM_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      min_sum_q <= pwdata[MIN_W-1:0];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(min_sum_q) : '0;

  rwc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_data_i.last_in_row),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rwc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .min_sum_i  (min_sum_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* verif/tb_row_weighted_centroid_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_weighted_centroid_unit: self-checking bench of the row centroid unit
// Streams gradient rows through the valid/ready input, predicts each row's
// centroid and flags in a scoreboard, and compares every output request in
// order. Threshold settings change over APB between drained phases.
// ----------------------------------------------------------------------------
module tb_row_weighted_centroid_unit;
  import rwc_pkg::*;

  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [APB_ADDR_W-1:0] ADDR_MIN_SUM = APB_ADDR_W'(4 * int'(REG_MIN_WEIGHT_SUM));
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED  =
    APB_ADDR_W'(4 * (int'(REG_MIN_WEIGHT_SUM) + 1));
  localparam logic [MIN_W-1:0] MIN_SUM_TOP = '1;

  typedef enum int {SHAPE_PEAK, SHAPE_RISING, SHAPE_NOISE, SHAPE_FAINT} row_shape_e;
  typedef enum int {RECV_ALWAYS, RECV_CHOPPY, RECV_SLOW} recv_mode_e;

  class centroid_scoreboard;
    rwc_out_t          expected_rows[$];
    logic [PACC_W-1:0] plain_sum;
    logic [WACC_W-1:0] weighted_sum;
    int unsigned       column;
    bit                past_limit;
    logic [MIN_W-1:0]  threshold;
    int                failures;
    int                rows_checked;
    int                below_seen;
    int                clamp_seen;
    int                long_seen;

    function new();
      clear_row();
      threshold    = MIN_SUM_RESET;
      failures     = 0;
      rows_checked = 0;
      below_seen   = 0;
      clamp_seen   = 0;
      long_seen    = 0;
    endfunction

    function void clear_row();
      plain_sum    = '0;
      weighted_sum = '0;
      column       = 0;
      past_limit   = 1'b0;
    endfunction

    function void note_sample(rwc_in_t s);
      longint   grad;
      longint   psum;
      longint   wsum;
      longint   quot;
      rwc_out_t row;
      grad = longint'($signed(s.gradient));
      // columns past the limit keep the last weight
      if (column < MAX_WIDTH) column++;
      else past_limit = 1'b1;
      plain_sum    = plain_sum + PACC_W'(grad);
      weighted_sum = weighted_sum + WACC_W'(longint'(column) * grad);
      if (!s.last_in_row) return;
      psum = longint'($signed(plain_sum));
      wsum = longint'($signed(weighted_sum));
      row  = '0;
      if (psum <= 0 || psum < longint'(threshold)) begin
        row.below_threshold = 1'b1;
      end else if (wsum < 0) begin
        row.clamped = 1'b1;
      end else begin
        // round to nearest, ties up
        quot = ((wsum <<< 8) + psum / 2) / psum;
        if (quot > LIMIT_INT) begin
          quot        = LIMIT_INT;
          row.clamped = 1'b1;
        end
        row.row_location = LOC_W'(quot);
      end
      row.too_long = past_limit;
      expected_rows.push_back(row);
      clear_row();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_row_result(rwc_out_t got);
      rwc_out_t want;
      if (expected_rows.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual loc %0d flags %b%b%b", $time,
                 got.row_location, got.below_threshold, got.clamped, got.too_long);
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      below_seen += want.below_threshold;
      clamp_seen += want.clamped;
      long_seen  += want.too_long;
      compare_field("row_location", want.row_location, got.row_location);
      compare_field("below_threshold", want.below_threshold, got.below_threshold);
      compare_field("clamped", want.clamped, got.clamped);
      compare_field("too_long", want.too_long, got.too_long);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  rwc_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  rwc_out_t              out_data_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  centroid_scoreboard sb;
  int unsigned        items_sent   = 0;
  int                 burst_left   = 0;
  int                 gap_pending  = 0;
  bit                 valid_high   = 1'b0;
  bit                 sender_idles = 1'b0;
  recv_mode_e         ready_mode   = RECV_ALWAYS;
  int                 hold_left    = 0;
  int                 quiet_cycles = 0;

  row_weighted_centroid_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: check accepted rows, then pick the next stall pattern step
  always @(posedge clk_i) begin
    bit stall;
    if (rst_ni && out_valid_o && out_ready_i) sb.check_row_result(out_data_o);
    if (hold_left > 0) begin
      hold_left--;
    end else if (ready_mode == RECV_ALWAYS) begin
      out_ready_i <= 1'b1;
    end else begin
      stall = ($urandom_range(0, 2) == 0);
      out_ready_i <= !stall;
      if (ready_mode == RECV_SLOW) hold_left = stall ? $urandom_range(4, 40) : $urandom_range(0, 8);
      else hold_left = $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_row_weighted_centroid_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic rwc_in_t make_sample(int grad, bit last);
    rwc_in_t s;
    s.gradient    = GRAD_W'(grad);
    s.last_in_row = last;
    return s;
  endfunction

  task automatic send_sample(input rwc_in_t s);
    if (gap_pending > 0) begin
      repeat (gap_pending) @(posedge clk_i);
      gap_pending = 0;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    valid_high = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_idles)
        gap_pending = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      // drop valid only when a gap follows
      if (gap_pending > 0) begin
        in_valid_i <= 1'b0;
        valid_high = 1'b0;
      end
    end
  endtask

  task automatic send_row(input int len, input row_shape_e shape);
    int peak_col;
    int amp;
    int slope;
    int offset;
    int value;
    peak_col = $urandom_range(1, len);
    amp      = $urandom_range(256, 32767);
    slope    = amp / $urandom_range(2, 9);
    for (int col = 1; col <= len; col++) begin
      case (shape)
        SHAPE_PEAK: begin
          offset = (col > peak_col) ? col - peak_col : peak_col - col;
          value  = amp - slope * offset;
          if (value < 0) value = int'($urandom_range(0, 40)) - 20;
        end
        SHAPE_RISING: value = $urandom_range(0, 32767);
        SHAPE_NOISE:  value = int'($signed(GRAD_W'($urandom)));
        default:      value = int'($urandom_range(0, 12)) - 5;
      endcase
      send_sample(make_sample(value, col == len));
    end
  endtask

  task automatic run_random_rows(input int target);
    int unsigned start;
    int          pick;
    int          len;
    row_shape_e  shape;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(13, 64);
      else                len = $urandom_range(65, 300);
      pick = $urandom_range(0, 99);
      if (pick < 40)      shape = SHAPE_PEAK;
      else if (pick < 60) shape = SHAPE_RISING;
      else if (pick < 80) shape = SHAPE_NOISE;
      else                shape = SHAPE_FAINT;
      send_row(len, shape);
    end
  endtask

  // hold off until every row result is back and the divider has gone quiet
  task automatic drain_rows();
    if (valid_high) begin
      in_valid_i <= 1'b0;
      valid_high = 1'b0;
    end
    burst_left  = 0;
    gap_pending = 0;
    while (sb.expected_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MIN_SUM) sb.threshold = data[MIN_W-1:0];
  endtask

  task automatic check_threshold_readback();
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MIN_SUM;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== APB_DATA_W'(sb.threshold)) begin
      sb.failures++;
      $display("%0t: min_weight_sum readback mismatch: expected %0d, actual %0d", $time,
               sb.threshold, got);
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_threshold_readback();

    // directed rows at reset threshold
    ready_mode = RECV_CHOPPY;
    send_sample(make_sample(32767, 1'b1));
    send_sample(make_sample(-32768, 1'b1));
    send_sample(make_sample(0, 1'b1));
    send_sample(make_sample(1, 1'b1));
    send_sample(make_sample(256, 1'b0));
    send_sample(make_sample(512, 1'b0));
    send_sample(make_sample(256, 1'b1));
    send_sample(make_sample(1000, 1'b0));
    send_sample(make_sample(-600, 1'b1));
    send_sample(make_sample(1000, 1'b0));
    send_sample(make_sample(-500, 1'b1));
    send_sample(make_sample(-30000, 1'b0));
    send_sample(make_sample(30001, 1'b1));
    send_sample(make_sample(511, 1'b0));
    send_sample(make_sample(1, 1'b1));
    send_sample(make_sample(-32768, 1'b0));
    send_sample(make_sample(32767, 1'b0));
    send_sample(make_sample(-1, 1'b0));
    send_sample(make_sample(21845, 1'b1));
    drain_rows();

    // threshold edge: equal passes, one below fails
    apb_write(ADDR_MIN_SUM, APB_DATA_W'(500));
    check_threshold_readback();
    send_sample(make_sample(500, 1'b1));
    send_sample(make_sample(499, 1'b1));
    drain_rows();
    apb_write(ADDR_UNUSED, APB_DATA_W'($urandom));
    check_threshold_readback();

    // long row: one sample past full
    apb_write(ADDR_MIN_SUM, APB_DATA_W'(1));
    sender_idles = 1'b1;
    send_row(MAX_WIDTH + 1, SHAPE_PEAK);
    drain_rows();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          apb_write(ADDR_MIN_SUM, '0);
          ready_mode = RECV_CHOPPY;
        end
        1: begin
          apb_write(ADDR_MIN_SUM, APB_DATA_W'($urandom_range(256, 8192)));
          ready_mode = RECV_SLOW;
        end
        2: begin
          apb_write(ADDR_MIN_SUM, APB_DATA_W'(MIN_SUM_TOP));
          ready_mode = RECV_CHOPPY;
        end
        3: begin
          apb_write(ADDR_MIN_SUM, APB_DATA_W'($urandom_range(8192, 2000000)));
          ready_mode = RECV_SLOW;
        end
        default: begin
          apb_write(ADDR_MIN_SUM, APB_DATA_W'(1));
          sender_idles = 1'b0;
          ready_mode   = RECV_ALWAYS;
        end
      endcase
      check_threshold_readback();
      run_random_rows(phase == 2 ? 80 : 160);
      drain_rows();
    end

    $display("Sent %0d samples; checked %0d rows over six threshold settings.",
             items_sent, sb.rows_checked);
    $display("Rows below threshold %0d, clamped %0d, too long %0d.",
             sb.below_seen, sb.clamp_seen, sb.long_seen);
    if (sb.failures == 0) begin
      $display("tb_row_weighted_centroid_unit: PASS");
    end else begin
      $display("tb_row_weighted_centroid_unit: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rwc_pkg.sv
rtl/rwc_div.sv
rtl/rwc_dp.sv
rtl/rwc_ctrl.sv
rtl/row_weighted_centroid_unit.sv
verif/tb_row_weighted_centroid_unit.sv
